>>> hw/rtl/battery_voltage_supervisor_macros.svh
// Assertion macros shared by the battery voltage supervisor RTL.
`ifndef BATTERY_VOLTAGE_SUPERVISOR_MACROS_SVH
`define BATTERY_VOLTAGE_SUPERVISOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define BVS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("battery supervisor check failed");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define BVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("battery supervisor check failed");
`else
`define BVS_ASSERT_IMP(label, ante, cons)
`define BVS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/bvs_pkg.sv
// Types, constants and helpers of the battery voltage supervisor.
`timescale 1ns / 1ps
`default_nettype none
package bvs_pkg;

    // Field widths.
    localparam int MAX_LANES  = 8;
    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int PIN_W      = 10;
    localparam int CELL_W     = 13;
    localparam int SCALED_W   = 14;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 12;
    localparam int PROD_W     = PIN_W + GAIN_W;
    localparam int RANK_W     = 3;
    localparam int LEVEL_W    = 13;
    localparam int MS_W       = 20;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Fixed limits of the measurement chain.
    localparam logic [SAMPLE_W-1:0] PIN_MIN_MV  = 12'd330;
    localparam logic [SAMPLE_W-1:0] PIN_MAX_MV  = 12'd560;
    localparam logic [SCALED_W-1:0] CELL_MAX_MV = 14'd4450;
    localparam logic [SCALED_W-1:0] JUMP_MAX_MV = 14'd350;

    // Register reset values.
    localparam logic                  RST_ENABLE   = 1'b1;
    localparam logic [GAIN_W-1:0]     RST_GAIN     = 16'd15155;
    localparam logic [LEVEL_W-1:0]    RST_LOW_MV   = 13'd3500;
    localparam logic [LEVEL_W-1:0]    RST_SHUT_MV  = 13'd3300;
    localparam logic [MS_W-1:0]       RST_HOLD_MS  = 20'd5000;
    localparam logic [LEVEL_W-1:0]    RST_MINV_MV  = 13'd2500;
    localparam logic [PERIOD_W-1:0]   RST_POLL_MS  = 16'd1000;
    localparam logic [MS_W-1:0]       RST_GUARD_MS = 20'd10000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 3'd0,
        CFG_GAIN   = 3'd1,
        CFG_LOW    = 3'd2,
        CFG_SHUT   = 3'd3,
        CFG_HOLD   = 3'd4,
        CFG_MINV   = 3'd5,
        CFG_POLL   = 3'd6,
        CFG_GUARD  = 3'd7
    } cfg_idx_t;

    // Input beat.
    typedef struct packed {
        logic [TIME_W-1:0]   time_ms;
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_7;
    } in_t;

    // Output beat.
    typedef struct packed {
        logic               shutdown_request;
        logic [CELL_W-1:0]  cell_mv;
        logic               reading_valid;
        logic               low_flag;
        logic               critical_flag;
        logic [PIN_W-1:0]   pin_mv;
    } out_t;

    // Thresholds used by the state update.
    typedef struct packed {
        logic [LEVEL_W-1:0] low_level_mv;
        logic [LEVEL_W-1:0] shutdown_level_mv;
        logic [MS_W-1:0]    hold_time_ms;
        logic [LEVEL_W-1:0] min_valid_mv;
    } thr_t;

    // Timing decisions made when a beat enters the pipeline.
    typedef struct packed {
        logic              en;
        logic              do_read;
        logic              guard_ok;
        logic [TIME_W-1:0] time_ms;
    } poll_ctx_t;

    // Everything the state update needs about one beat.
    typedef struct packed {
        poll_ctx_t           poll;
        logic                pin_ok;
        logic [PIN_W-1:0]    pin;
        logic [SCALED_W-1:0] cell_scaled;
    } upd_ctx_t;

    // Picks one pin sample out of an input beat.
    function automatic logic [SAMPLE_W-1:0] sample_of(input in_t d, input int unsigned idx);
        logic [SAMPLE_W-1:0] s;
        case (idx)
            0:       s = d.sample_0;
            1:       s = d.sample_1;
            2:       s = d.sample_2;
            3:       s = d.sample_3;
            4:       s = d.sample_4;
            5:       s = d.sample_5;
            6:       s = d.sample_6;
            7:       s = d.sample_7;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/battery_voltage_supervisor.sv
// Top level of the battery voltage supervisor: handshake, timing and pipeline.
//
// Usage: each input beat on in_valid/in_stall/in_data carries a millisecond
// timestamp and eight pin samples; every accepted beat yields exactly one
// result beat on out_valid/out_stall/out_data, in order. Registers are written
// through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high and
// writes are meant to happen only while no beat is in flight.
// Each accepted beat passes through four register stages: the rank lanes with
// the poll timer, the median merge, the gain multiplier, and the state update
// that loads the output register. A new beat can be accepted every cycle while
// the pipeline is not held up by a stalling receiver.
// Reset empties the pipeline, restores the register defaults and clears the
// supervisor state; the block can accept a beat in the first cycle after it.
// When the receiver stalls, the result is held in the output register and
// stages behind it keep filling; in_stall rises only once every stage is full.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_voltage_supervisor_macros.svh"
module battery_voltage_supervisor #(
    parameter int SAMPLES_PER_POLL = 8,
    parameter int SHUTDOWN_ENABLE  = 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  bvs_pkg::in_t                       in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bvs_pkg::out_t                      out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bvs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bvs_pkg::*;

    localparam int LANES = (SAMPLES_PER_POLL < 2) ? 2 :
                           (SAMPLES_PER_POLL > MAX_LANES) ? MAX_LANES : SAMPLES_PER_POLL;
    localparam bit SD_EN = (SHUTDOWN_ENABLE != 0);

    // Configuration registers.
    logic                enable_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [LEVEL_W-1:0]  low_mv_reg;
    logic [LEVEL_W-1:0]  shut_mv_reg;
    logic [MS_W-1:0]     hold_ms_reg;
    logic [LEVEL_W-1:0]  minv_mv_reg;
    logic [PERIOD_W-1:0] poll_ms_reg;
    logic [MS_W-1:0]     guard_ms_reg;
    thr_t                thr;

    // Poll timer state.
    logic [TIME_W-1:0] boot_time_reg, boot_time_next;
    logic              boot_seen_reg, boot_seen_next;
    logic [TIME_W-1:0] last_poll_reg, last_poll_next;
    logic              poll_seen_reg, poll_seen_next;
    poll_ctx_t         poll_ctx;

    // Pipeline occupancy and handshake.
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic vo_reg, vo_next;
    logic accept, ld2, ld3, ld_o;
    logic free1, free2, free3;

    // Stage payloads.
    logic [LANES-1:0][SAMPLE_W-1:0] lane_sample;
    logic [LANES-1:0][RANK_W-1:0]   lane_rank;
    logic [LANES-1:0][SAMPLE_W-1:0] s1_sample_reg;
    logic [LANES-1:0][RANK_W-1:0]   s1_rank_reg;
    poll_ctx_t                      s1_ctx_reg;
    poll_ctx_t                      s2_ctx_reg;
    logic [PIN_W-1:0]               s2_pin_reg;
    logic                           s2_pin_ok_reg;
    logic [PROD_W-1:0]              product;
    upd_ctx_t                       s3_reg;
    out_t                           result;
    out_t                           out_data_reg;

    // Bubble-collapsing handshake: a stage loads when the one ahead is free.
    always_comb
    begin
        ld_o     = v3_reg && (!vo_reg || !out_stall);
        free3    = !v3_reg || ld_o;
        ld3      = v2_reg && free3;
        free2    = !v2_reg || ld3;
        ld2      = v1_reg && free2;
        free1    = !v1_reg || ld2;
        in_stall = !free1;
        accept   = in_valid && free1;
        v1_next  = accept ? 1'b1 : (ld2 ? 1'b0 : v1_reg);
        v2_next  = ld2 ? 1'b1 : (ld3 ? 1'b0 : v2_reg);
        v3_next  = ld3 ? 1'b1 : (ld_o ? 1'b0 : v3_reg);
        vo_next  = ld_o ? 1'b1 : (out_stall ? vo_reg : 1'b0);
    end

    assign out_valid = vo_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        thr.low_level_mv      = low_mv_reg;
        thr.shutdown_level_mv = shut_mv_reg;
        thr.hold_time_ms      = hold_ms_reg;
        thr.min_valid_mv      = minv_mv_reg;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= RST_ENABLE;
            gain_reg     <= RST_GAIN;
            low_mv_reg   <= RST_LOW_MV;
            shut_mv_reg  <= RST_SHUT_MV;
            hold_ms_reg  <= RST_HOLD_MS;
            minv_mv_reg  <= RST_MINV_MV;
            poll_ms_reg  <= RST_POLL_MS;
            guard_ms_reg <= RST_GUARD_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLE: enable_reg   <= cfg_data[0];
                CFG_GAIN:   gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_LOW:    low_mv_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_SHUT:   shut_mv_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_HOLD:   hold_ms_reg  <= cfg_data[MS_W-1:0];
                CFG_MINV:   minv_mv_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_POLL:   poll_ms_reg  <= cfg_data[PERIOD_W-1:0];
                CFG_GUARD:  guard_ms_reg <= cfg_data[MS_W-1:0];
                default:    ;
            endcase
        end
    end

    // Poll timer: boot latch, poll due test and startup guard at acceptance.
    always_comb
    begin
        logic [TIME_W-1:0] boot_base;
        boot_base      = boot_seen_reg ? boot_time_reg : in_data.time_ms;
        boot_time_next = boot_base;
        boot_seen_next = boot_seen_reg || enable_reg;
        poll_ctx.en       = enable_reg;
        poll_ctx.time_ms  = in_data.time_ms;
        poll_ctx.guard_ok = (in_data.time_ms - boot_base) >= TIME_W'(guard_ms_reg);
        poll_ctx.do_read  = enable_reg && (!poll_seen_reg ||
                            ((in_data.time_ms - last_poll_reg) >= TIME_W'(poll_ms_reg)));
        last_poll_next    = poll_ctx.do_read ? in_data.time_ms : last_poll_reg;
        poll_seen_next    = poll_seen_reg || poll_ctx.do_read;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_time_reg <= '0;
            boot_seen_reg <= 1'b0;
            last_poll_reg <= '0;
            poll_seen_reg <= 1'b0;
        end
        else if (accept && enable_reg)
        begin
            boot_time_reg <= boot_time_next;
            boot_seen_reg <= boot_seen_next;
            last_poll_reg <= last_poll_next;
            poll_seen_reg <= poll_seen_next;
        end
    end

    // Rank lanes, one per used sample.
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        assign lane_sample[i] = sample_of(in_data, i);
        bvs_rank_lane #(
            .LANES (LANES),
            .LANE  (i)
        ) u_lane (
            .samples (lane_sample),
            .rank    (lane_rank[i])
        );
    end

    // Median merge stage.
    bvs_median_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk        (clk),
        .load       (ld2),
        .samples    (s1_sample_reg),
        .ranks      (s1_rank_reg),
        .pin_reg    (s2_pin_reg),
        .pin_ok_reg (s2_pin_ok_reg)
    );

    // Gain multiply: cell mV is the pin mV times the Q4.12 gain, with the fraction dropped.
    assign product = PROD_W'(s2_pin_reg) * PROD_W'(gain_reg);

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= lane_sample;
            s1_rank_reg   <= lane_rank;
            s1_ctx_reg    <= poll_ctx;
        end
        if (ld2)
        begin
            s2_ctx_reg <= s1_ctx_reg;
        end
        if (ld3)
        begin
            s3_reg.poll        <= s2_ctx_reg;
            s3_reg.pin_ok      <= s2_pin_ok_reg;
            s3_reg.pin         <= s2_pin_reg;
            s3_reg.cell_scaled <= product[PROD_W-1:FRAC_W];
        end
        if (ld_o)
        begin
            out_data_reg <= result;
        end
    end

    // State update feeding the output register.
    bvs_state_update #(
        .SHUTDOWN_ENABLE (SD_EN)
    ) u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (ld_o),
        .ctx    (s3_reg),
        .thr    (thr),
        .res    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    // Accepted beats enter stage one, loads reach the output, and a full pipe stalls.
    `BVS_ASSERT_NEXT(a_accept_fills, accept, v1_reg)
    `BVS_ASSERT_NEXT(a_load_shows, ld_o, out_valid)
    `BVS_ASSERT_IMP(a_full_stalls, v1_reg && v2_reg && v3_reg && vo_reg && out_stall, in_stall)

endmodule
`default_nettype wire

>>> hw/rtl/bvs_rank_lane.sv
// One sorting lane: finds the rank of its own sample among all lanes.
`timescale 1ns / 1ps
`default_nettype none
module bvs_rank_lane #(
    parameter int LANES = 8,
    parameter int LANE  = 0
) (
    input  logic [LANES-1:0][bvs_pkg::SAMPLE_W-1:0] samples,
    output logic [bvs_pkg::RANK_W-1:0]               rank
);
    import bvs_pkg::*;

    // Count the samples that sort ahead of this one; ties go to the lower lane.
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < LANES; j++)
        begin
            if (j != LANE)
            begin
                if ((samples[j] < samples[LANE]) ||
                    ((samples[j] == samples[LANE]) && (j < LANE)))
                begin
                    rank = rank + RANK_W'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/bvs_median_merge.sv
// Merge stage: picks the two middle-ranked samples and registers their mean.
`timescale 1ns / 1ps
`default_nettype none
module bvs_median_merge #(
    parameter int LANES = 8
) (
    input  logic                                     clk,
    input  logic                                     load,
    input  logic [LANES-1:0][bvs_pkg::SAMPLE_W-1:0]  samples,
    input  logic [LANES-1:0][bvs_pkg::RANK_W-1:0]    ranks,
    output logic [bvs_pkg::PIN_W-1:0]                pin_reg,
    output logic                                     pin_ok_reg
);
    import bvs_pkg::*;

    localparam logic [RANK_W-1:0] RANK_LO = RANK_W'(LANES / 2 - 1);
    localparam logic [RANK_W-1:0] RANK_HI = RANK_W'(LANES / 2);

    logic [SAMPLE_W-1:0] lo_sample;
    logic [SAMPLE_W-1:0] hi_sample;
    logic [SAMPLE_W:0]   pair_sum;
    logic [SAMPLE_W-1:0] mean;
    logic [PIN_W-1:0]    pin_next;
    logic                pin_ok_next;

    // Ranks are unique, so each middle rank selects exactly one lane.
    always_comb
    begin
        lo_sample = '0;
        hi_sample = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (ranks[i] == RANK_LO)
            begin
                lo_sample = lo_sample | samples[i];
            end
            if (ranks[i] == RANK_HI)
            begin
                hi_sample = hi_sample | samples[i];
            end
        end
    end

    // Floor mean of the middle pair and the pin window check.
    always_comb
    begin
        pair_sum    = {1'b0, lo_sample} + {1'b0, hi_sample};
        mean        = pair_sum[SAMPLE_W:1];
        pin_ok_next = (mean >= PIN_MIN_MV) && (mean <= PIN_MAX_MV);
        pin_next    = mean[PIN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pin_reg    <= pin_next;
            pin_ok_reg <= pin_ok_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/bvs_state_update.sv
// Supervisor state: smoothing, level flags and the shutdown hold timer.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_voltage_supervisor_macros.svh"
module bvs_state_update #(
    parameter bit SHUTDOWN_ENABLE = 1'b1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  bvs_pkg::upd_ctx_t ctx,
    input  bvs_pkg::thr_t     thr,
    output bvs_pkg::out_t     res
);
    import bvs_pkg::*;

    logic [CELL_W-1:0] smoothed_reg, smoothed_next;
    logic              primed_reg, primed_next;
    logic              valid_reg, valid_next;
    logic              low_reg, low_next;
    logic              crit_reg, crit_next;
    logic [PIN_W-1:0]  pin_reg, pin_next;
    logic [TIME_W-1:0] below_since_reg, below_since_next;
    logic              below_active_reg, below_active_next;

    logic [SCALED_W-1:0] sm_wide;
    logic [SCALED_W-1:0] diff;
    logic                jump_bad;
    logic                take;
    logic [CELL_W-1:0]   cell13;
    logic [SCALED_W-1:0] pair_sum;
    logic [CELL_W-1:0]   sm_new;
    logic [TIME_W-1:0]   below_elapsed;
    logic                req;

    // Screen the scaled reading and form the new smoothed value.
    always_comb
    begin
        sm_wide  = SCALED_W'(smoothed_reg);
        diff     = (ctx.cell_scaled > sm_wide) ? (ctx.cell_scaled - sm_wide)
                                               : (sm_wide - ctx.cell_scaled);
        jump_bad = primed_reg && valid_reg && (diff > JUMP_MAX_MV);
        take     = ctx.poll.en && ctx.poll.do_read && ctx.pin_ok &&
                   (ctx.cell_scaled >= SCALED_W'(thr.min_valid_mv)) &&
                   (ctx.cell_scaled <= CELL_MAX_MV) && !jump_bad;
        cell13   = ctx.cell_scaled[CELL_W-1:0];
        pair_sum = sm_wide + SCALED_W'(cell13);
        sm_new   = primed_reg ? pair_sum[SCALED_W-1:1] : cell13;
    end

    // Level flags follow the smoothed value whenever a reading is taken.
    always_comb
    begin
        smoothed_next = smoothed_reg;
        primed_next   = primed_reg;
        valid_next    = valid_reg;
        low_next      = low_reg;
        crit_next     = crit_reg;
        pin_next      = pin_reg;
        if (take)
        begin
            smoothed_next = sm_new;
            primed_next   = 1'b1;
            pin_next      = ctx.pin;
            valid_next    = sm_new >= thr.min_valid_mv;
            crit_next     = valid_next && (sm_new < thr.shutdown_level_mv);
            low_next      = valid_next && (crit_next || (sm_new < thr.low_level_mv));
        end
    end

    // Shutdown hold timer; the guard decision arrives with the beat.
    always_comb
    begin
        below_since_next  = below_since_reg;
        below_active_next = below_active_reg;
        below_elapsed     = ctx.poll.time_ms - below_since_reg;
        req               = 1'b0;
        if (SHUTDOWN_ENABLE && ctx.poll.en)
        begin
            if (!valid_next || !ctx.poll.guard_ok)
            begin
                below_active_next = 1'b0;
            end
            else if (smoothed_next < thr.shutdown_level_mv)
            begin
                if (!below_active_reg)
                begin
                    below_since_next  = ctx.poll.time_ms;
                    below_active_next = 1'b1;
                    req               = (thr.hold_time_ms == '0);
                end
                else
                begin
                    req = below_elapsed >= TIME_W'(thr.hold_time_ms);
                end
            end
            else
            begin
                below_active_next = 1'b0;
            end
        end
    end

    // Result beat shows the state after this item.
    always_comb
    begin
        res.shutdown_request = req;
        res.cell_mv          = smoothed_next;
        res.reading_valid    = valid_next;
        res.low_flag         = low_next;
        res.critical_flag    = crit_next;
        res.pin_mv           = pin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg     <= '0;
            primed_reg       <= 1'b0;
            valid_reg        <= 1'b0;
            low_reg          <= 1'b0;
            crit_reg         <= 1'b0;
            pin_reg          <= '0;
            below_since_reg  <= '0;
            below_active_reg <= 1'b0;
        end
        else if (commit)
        begin
            smoothed_reg     <= smoothed_next;
            primed_reg       <= primed_next;
            valid_reg        <= valid_next;
            low_reg          <= low_next;
            crit_reg         <= crit_next;
            pin_reg          <= pin_next;
            below_since_reg  <= below_since_next;
            below_active_reg <= below_active_next;
        end
    end

    // Critical implies low, low implies valid, and nothing is stored before priming.
    `BVS_ASSERT_IMP(a_crit_is_low, crit_reg, low_reg)
    `BVS_ASSERT_IMP(a_low_is_valid, low_reg, valid_reg)
    `BVS_ASSERT_IMP(a_unprimed_empty, !primed_reg, (smoothed_reg == '0) && !valid_reg)

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the battery voltage supervisor: stimulus, prediction and checks.
`timescale 1ns / 1ps
module testbench;
    import bvs_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int LANES          = 8;
    localparam int SHUT_EN        = 1;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_BEATS    = 235;

    // Clock, reset and block ports.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_t                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Beats waiting to be driven and status words waiting to come out.
    in_t  beats_to_send [$];
    out_t status_due [$];

    // Idle rates and the long receiver hold-off handshake between processes.
    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 71;
    int          hold_requests = 0;
    int          hold_grants   = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;

    // Run statistics.
    int errors         = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int shutdown_seen  = 0;
    int critical_seen  = 0;
    int low_seen       = 0;
    int settings_used  = 0;

    // Random walk of the pin level used by the well-formed stimulus.
    int          pin_level  = 450;
    int          pin_center = 450;
    logic [31:0] clock_ms   = '0;

    // Predictor copy of the configuration registers.
    logic                m_enable = RST_ENABLE;
    logic [GAIN_W-1:0]   m_gain   = RST_GAIN;
    logic [LEVEL_W-1:0]  m_low    = RST_LOW_MV;
    logic [LEVEL_W-1:0]  m_shut   = RST_SHUT_MV;
    logic [MS_W-1:0]     m_hold   = RST_HOLD_MS;
    logic [LEVEL_W-1:0]  m_minv   = RST_MINV_MV;
    logic [PERIOD_W-1:0] m_poll   = RST_POLL_MS;
    logic [MS_W-1:0]     m_guard  = RST_GUARD_MS;

    // Predictor copy of the supervisor state.
    logic [CELL_W-1:0] smooth_mv = '0;
    logic              primed    = 1'b0;
    logic              valid_now = 1'b0;
    logic              low_now   = 1'b0;
    logic              crit_now  = 1'b0;
    logic [PIN_W-1:0]  pin_held  = '0;
    logic [TIME_W-1:0] boot_ms   = '0;
    logic [TIME_W-1:0] poll_ms   = '0;
    logic [TIME_W-1:0] below_ms  = '0;
    logic              booted    = 1'b0;
    logic              polled    = 1'b0;
    logic              below_on  = 1'b0;

    battery_voltage_supervisor #(
        .SAMPLES_PER_POLL(LANES),
        .SHUTDOWN_ENABLE (SHUT_EN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Updates the predictor's register copy after a register write.
    function automatic void apply_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_ENABLE: m_enable = value[0];
            CFG_GAIN:   m_gain   = value[GAIN_W-1:0];
            CFG_LOW:    m_low    = value[LEVEL_W-1:0];
            CFG_SHUT:   m_shut   = value[LEVEL_W-1:0];
            CFG_HOLD:   m_hold   = value[MS_W-1:0];
            CFG_MINV:   m_minv   = value[LEVEL_W-1:0];
            CFG_POLL:   m_poll   = value[PERIOD_W-1:0];
            CFG_GUARD:  m_guard  = value[MS_W-1:0];
            default:    ;
        endcase
    endfunction

    // Advances the predicted supervisor state by one beat and returns its status word.
    function automatic out_t predict_status(in_t beat);
        logic [7:0][SAMPLE_W-1:0] lane;
        logic [SAMPLE_W-1:0]      swap;
        logic [SAMPLE_W:0]        pair_sum;
        logic [SAMPLE_W-1:0]      pin;
        logic [31:0]              cell_val;
        logic [31:0]              diff;
        logic [31:0]              elapsed;
        logic                     take;
        logic                     req;
        int                       n;
        out_t                     status;

        req = 1'b0;
        if (m_enable)
        begin
            if (!booted)
            begin
                boot_ms = beat.time_ms;
                booted  = 1'b1;
            end

            // Poll when due: median of the lanes, window, range and jump screens.
            elapsed = beat.time_ms - poll_ms;
            if (!polled || elapsed >= 32'(m_poll))
            begin
                poll_ms = beat.time_ms;
                polled  = 1'b1;
                lane = {beat.sample_7, beat.sample_6, beat.sample_5, beat.sample_4,
                        beat.sample_3, beat.sample_2, beat.sample_1, beat.sample_0};
                n = LANES;
                if (n < 2)
                    n = 2;
                if (n > 8)
                    n = 8;
                for (int a = 0; a < n - 1; a++)
                    for (int b = a + 1; b < n; b++)
                        if (lane[b] < lane[a])
                        begin
                            swap    = lane[a];
                            lane[a] = lane[b];
                            lane[b] = swap;
                        end
                pair_sum = lane[n / 2 - 1] + lane[n / 2];
                pin      = pair_sum[SAMPLE_W:1];
                if (pin >= PIN_MIN_MV && pin <= PIN_MAX_MV)
                begin
                    cell_val = (32'(pin) * 32'(m_gain)) >> FRAC_W;
                    take = (cell_val >= 32'(m_minv)) && (cell_val <= 32'(CELL_MAX_MV));
                    if (take && primed && valid_now)
                    begin
                        diff = (cell_val > 32'(smooth_mv)) ? cell_val - 32'(smooth_mv)
                                                           : 32'(smooth_mv) - cell_val;
                        take = diff <= 32'(JUMP_MAX_MV);
                    end
                    if (take)
                    begin
                        pin_held = pin[PIN_W-1:0];
                        if (!primed)
                        begin
                            smooth_mv = cell_val[CELL_W-1:0];
                            primed    = 1'b1;
                        end
                        else
                            smooth_mv = CELL_W'((32'(smooth_mv) + cell_val) >> 1);
                        valid_now = smooth_mv >= m_minv;
                        crit_now  = valid_now && (smooth_mv < m_shut);
                        low_now   = valid_now && (crit_now || smooth_mv < m_low);
                    end
                end
            end

            // Shutdown request once critical has held past the guard and hold times.
            if (SHUT_EN != 0)
            begin
                elapsed = beat.time_ms - boot_ms;
                if (!valid_now || elapsed < 32'(m_guard))
                    below_on = 1'b0;
                else if (smooth_mv < m_shut)
                begin
                    if (!below_on)
                    begin
                        below_ms = beat.time_ms;
                        below_on = 1'b1;
                    end
                    elapsed = beat.time_ms - below_ms;
                    req = elapsed >= 32'(m_hold);
                end
                else
                    below_on = 1'b0;
            end
        end

        status.shutdown_request = req;
        status.cell_mv          = smooth_mv;
        status.reading_valid    = valid_now;
        status.low_flag         = low_now;
        status.critical_flag    = crit_now;
        status.pin_mv           = pin_held;
        return status;
    endfunction

    // Builds an input beat from a timestamp and eight lane readings.
    function automatic in_t pack_beat(logic [31:0] t, logic [7:0][SAMPLE_W-1:0] s);
        in_t beat;
        beat.time_ms  = t;
        beat.sample_0 = s[0];
        beat.sample_1 = s[1];
        beat.sample_2 = s[2];
        beat.sample_3 = s[3];
        beat.sample_4 = s[4];
        beat.sample_5 = s[5];
        beat.sample_6 = s[6];
        beat.sample_7 = s[7];
        return beat;
    endfunction

    // Builds a beat whose lanes all read the same value.
    function automatic in_t flat_beat(logic [31:0] t, logic [SAMPLE_W-1:0] v);
        return pack_beat(t, {8{v}});
    endfunction

    // Reports one field of a status word that differs from the prediction.
    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Driver: offers queued beats, holding each one until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                status_due.push_back(predict_status(in_data));
                beats_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= beats_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction and drives stall.
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                shutdown_seen += out_data.shutdown_request;
                critical_seen += out_data.critical_flag;
                low_seen      += out_data.low_flag;
                if (status_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, out_data);
                    errors++;
                end
                else
                begin
                    want = status_due.pop_front();
                    report_field("shutdown_request", want.shutdown_request,
                                 out_data.shutdown_request);
                    report_field("cell_mv", want.cell_mv, out_data.cell_mv);
                    report_field("reading_valid", want.reading_valid, out_data.reading_valid);
                    report_field("low_flag", want.low_flag, out_data.low_flag);
                    report_field("critical_flag", want.critical_flag, out_data.critical_flag);
                    report_field("pin_mv", want.pin_mv, out_data.pin_mv);
                end
            end
            if (hold_grants != hold_requests)
            begin
                hold_left = LONG_HOLD;
                hold_grants++;
            end
            else if (hold_left > 0)
                hold_left--;
            out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Counts cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Ends the run when the block stops making progress.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // Writes one register; entered at a rising edge, returns at the accepting edge.
    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, value);
    endtask

    // Writes every register and aims the pin walk at the critical threshold.
    task automatic configure(logic en, logic [15:0] gain, logic [12:0] low,
                             logic [12:0] shut, logic [19:0] hold, logic [12:0] minv,
                             logic [15:0] poll, logic [19:0] guard);
        @(posedge clk);
        write_register(CFG_ENABLE, CFG_DATA_W'(en));
        write_register(CFG_GAIN, CFG_DATA_W'(gain));
        write_register(CFG_LOW, CFG_DATA_W'(low));
        write_register(CFG_SHUT, CFG_DATA_W'(shut));
        write_register(CFG_HOLD, CFG_DATA_W'(hold));
        write_register(CFG_MINV, CFG_DATA_W'(minv));
        write_register(CFG_POLL, CFG_DATA_W'(poll));
        write_register(CFG_GUARD, CFG_DATA_W'(guard));
        cfg_valid <= 1'b0;
        settings_used++;
        pin_center = (gain == 0) ? 450 : int'((32'(shut) << FRAC_W) / 32'(gain));
        if (pin_center < 330)
            pin_center = 330;
        if (pin_center > 560)
            pin_center = 560;
    endtask

    // Waits until every beat has been taken and every result has come out.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (beats_to_send.size() != 0 || in_valid || status_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Directed beats: first poll, window edges, outliers, critical hold, extremes, wrap.
    task automatic queue_directed_beats();
        logic [7:0][SAMPLE_W-1:0] s;
        beats_to_send.push_back(flat_beat(32'd1000, 12'd450));
        beats_to_send.push_back(flat_beat(32'd1002, 12'd400));
        beats_to_send.push_back(flat_beat(32'd1005, 12'd329));
        beats_to_send.push_back(flat_beat(32'd1010, 12'd561));
        beats_to_send.push_back(flat_beat(32'd1015, 12'd330));
        beats_to_send.push_back(flat_beat(32'd1020, 12'd560));
        for (int k = 0; k < 8; k++)
            s[k] = (k < 4) ? ((k % 2 != 0) ? 12'd4095 : 12'd0) : 12'd440;
        beats_to_send.push_back(pack_beat(32'd1025, s));
        for (int k = 0; k < 8; k++)
            s[k] = SAMPLE_W'(401 + (k * 3) % 8);
        beats_to_send.push_back(pack_beat(32'd1030, s));
        beats_to_send.push_back(flat_beat(32'd1035, 12'd401));
        for (int k = 0; k < 5; k++)
            beats_to_send.push_back(flat_beat(32'(1040 + 5 * k), 12'd400));
        beats_to_send.push_back(flat_beat(32'd1062, 12'd4095));
        beats_to_send.push_back(flat_beat(32'd1065, 12'd0));
        beats_to_send.push_back(flat_beat(32'd1070, 12'haaa));
        beats_to_send.push_back(flat_beat(32'd1075, 12'h555));
        beats_to_send.push_back(flat_beat(32'hffff_fffe, 12'd440));
        beats_to_send.push_back(flat_beat(32'h0000_0003, 12'd440));
        beats_to_send.push_back(flat_beat(32'h0000_0004, 12'd445));
        clock_ms = 32'd5;
    endtask

    // Random beats: mostly a drifting pin level with jitter and outliers, some noise.
    task automatic queue_random_beats(int count);
        logic [7:0][SAMPLE_W-1:0] s;
        logic [31:0]              t;
        int                       v;
        int                       step_max;
        step_max = (m_poll == 0) ? 2 : int'(m_poll) + int'(m_poll) / 2;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 8)
            begin
                // Noise: any timestamp, any lane values.
                t = $urandom;
                for (int k = 0; k < 8; k++)
                    s[k] = SAMPLE_W'($urandom_range(0, 4095));
            end
            else
            begin
                // Well-formed: level drifts toward the threshold, time moves forward.
                if ($urandom_range(99) < 4)
                    pin_level += int'($urandom_range(0, 240)) - 120;
                else
                    pin_level += int'($urandom_range(0, 10)) - 5
                                 + ((pin_level < pin_center) ? 1 : 0)
                                 - ((pin_level > pin_center) ? 1 : 0);
                if (pin_level < 300)
                    pin_level = 300;
                if (pin_level > 600)
                    pin_level = 600;
                if ($urandom_range(99) < 3)
                    clock_ms += $urandom;
                else
                    clock_ms += $urandom_range(0, step_max);
                t = clock_ms;
                for (int k = 0; k < 8; k++)
                begin
                    v = pin_level + int'($urandom_range(0, 8)) - 4;
                    s[k] = SAMPLE_W'((v < 0) ? 0 : (v > 4095) ? 4095 : v);
                end
                if ($urandom_range(99) < 30)
                    s[$urandom_range(0, 7)] = SAMPLE_W'($urandom_range(0, 4095));
                if ($urandom_range(99) < 15)
                    s[$urandom_range(0, 7)] = SAMPLE_W'($urandom_range(0, 4095));
            end
            beats_to_send.push_back(pack_beat(t, s));
        end
    endtask

    // Test sequence: directed checks, then random phases under varied settings and idling.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        configure(1'b1, 16'd32768, 13'd3500, 13'd3300, 20'd20, 13'd2500, 16'd5, 20'd30);
        queue_directed_beats();
        wait_idle();

        // Disabled block holds its state.
        configure(1'b0, 16'd32768, 13'd3500, 13'd3300, 20'd20, 13'd2500, 16'd5, 20'd30);
        beats_to_send.push_back(flat_beat(32'd10, 12'd350));
        beats_to_send.push_back(flat_beat(32'd5000, 12'd500));
        beats_to_send.push_back(flat_beat(32'hffff_ffff, 12'd0));
        wait_idle();

        // Sender idles lightly, receiver heavily; the sender pauses once midway.
        configure(1'b1, 16'd32768, 13'd3500, 13'd3300, 20'd50, 13'd2500, 16'd10, 20'd100);
        queue_random_beats(PHASE_BEATS / 2);
        wait_idle();
        queue_random_beats(PHASE_BEATS - PHASE_BEATS / 2);
        wait_idle();
        configure(1'b1, 16'd65535, 13'd4450, 13'd4450, 20'd0, 13'd0, 16'd0, 20'd0);
        queue_random_beats(PHASE_BEATS);
        wait_idle();
        configure(1'b1, 16'd0, 13'd0, 13'd0, 20'd1048575, 13'd0, 16'd65535, 20'd1048575);
        queue_random_beats(PHASE_BEATS);
        wait_idle();

        // Sender idles heavily, receiver lightly.
        send_idle_pct = 71;
        recv_idle_pct = 15;
        configure(1'b1, 16'd36000, 13'd4000, 13'd3700, 20'd200, 13'd3000, 16'd20, 20'd500);
        queue_random_beats(PHASE_BEATS);
        wait_idle();
        configure(1'b1, 16'd30000, 13'd3400, 13'd3200, 20'd10, 13'd2600, 16'd1, 20'd0);
        queue_random_beats(PHASE_BEATS);
        wait_idle();
        configure(1'b1, 16'd33000, 13'd3800, 13'd3600, 20'd100, 13'd3300, 16'd8, 20'd2000);
        queue_random_beats(PHASE_BEATS);
        wait_idle();

        // No idling; the receiver holds off for a long stretch so the block backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(1'b1, 16'd32768, 13'd3600, 13'd3500, 20'd30, 13'd2800, 16'd3, 20'd50);
        queue_random_beats(PHASE_BEATS);
        @(negedge clk);
        hold_requests++;
        wait_idle();
        configure(1'b1, 16'd28000, 13'd3300, 13'd3000, 20'd1000, 13'd2400, 16'd50, 20'd10000);
        queue_random_beats(PHASE_BEATS);
        wait_idle();

        $display("Sent %0d beats under %0d register settings and checked %0d results.",
                 beats_sent, settings_used, results_seen);
        $display("Results with shutdown request: %0d, critical: %0d, low: %0d.",
                 shutdown_seen, critical_seen, low_seen);
        if (errors == 0 && status_due.size() == 0)
            $display("testbench OK");
        else
        begin
            if (status_due.size() != 0)
                $display("%0t: %0d results expected but never seen", $time, status_due.size());
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
